// ===== sv/color_blob_centroid_defines.svh =====
// ----------------------------------------------------------------------------
// color_blob_centroid_defines.svh
// Assertion helper macros shared by the blob centroid modules.
// ----------------------------------------------------------------------------
`ifndef COLOR_BLOB_CENTROID_DEFINES_SVH
`define COLOR_BLOB_CENTROID_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CBC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define CBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared constants and types for the color blob centroid block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbc_pkg;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Field widths
  localparam int COLOR_W  = 8;
  localparam int COORD_W  = 10;
  localparam int REG_W    = 11;
  localparam int PROD_W   = COLOR_W + 3;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Blue must beat this multiple of red and of green
  localparam int MATCH_GAIN = 5;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [REG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [REG_W-1:0] RST_FRAME_HEIGHT = 11'd480;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== sv/cbc_divider.sv =====
// ----------------------------------------------------------------------------
// cbc_divider
// Shared restoring divider, one quotient bit per cycle.
// The quotient is known to fit QW bits, so the upper part of the dividend
// seeds the remainder and only QW steps are run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "color_blob_centroid_defines.svh"

module cbc_divider #(
  parameter int QW    = 10,
  parameter int CNT_W = 21
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [QW+CNT_W-1:0]    dividend,
  input  logic [CNT_W-1:0]       divisor,
  output cbc_pkg::div_status_t   status,
  output logic [QW-1:0]          quotient
);

  localparam int SUM_W = QW + CNT_W;
  localparam int SW    = $clog2(QW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SW-1:0]    steps_r, steps_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0] divisor_r, divisor_nxt;

  logic [CNT_W:0]   shifted;
  logic [CNT_W:0]   diff;
  logic             ge;
  logic [QW:0]      lo_shift;

  // One trial subtract
  always_comb begin
    shifted  = {rem_r, lo_r[QW-1]};
    ge       = (shifted >= {1'b0, divisor_r});
    diff     = shifted - {1'b0, divisor_r};
    lo_shift = {lo_r, ge};
  end

  // Step control
  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    steps_nxt   = steps_r;
    rem_nxt     = rem_r;
    lo_nxt      = lo_r;
    divisor_nxt = divisor_r;
    if (start) begin
      busy_nxt    = 1'b1;
      steps_nxt   = SW'(QW);
      rem_nxt     = dividend[SUM_W-1:QW];
      lo_nxt      = dividend[QW-1:0];
      divisor_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt   = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      lo_nxt    = lo_shift[QW-1:0];
      steps_nxt = steps_r - SW'(1);
      if (steps_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      steps_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      steps_r <= steps_nxt;
    end
    rem_r     <= rem_nxt;
    lo_r      <= lo_nxt;
    divisor_r <= divisor_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = lo_r;

  `CBC_ASSERT_NEXT(a_last_step_done, busy_r && !start && steps_r == SW'(1), done_r && !busy_r, "divider did not finish after its last step")

endmodule

// ===== sv/color_blob_centroid.sv =====
// ----------------------------------------------------------------------------
// color_blob_centroid
// Blue blob centroid over one raster frame of RGB pixels.
// ----------------------------------------------------------------------------
// Pixels enter on the in_ stream, one word per pixel, columns fastest.
// A pixel counts when blue > 5*red and blue > 5*green; its column and row
// are summed and it is counted. The frame size comes from the frame_width
// and frame_height registers on the cfg_ port, clamped to 1..MAX.
// Pixels are taken one per clock within a frame. After the frame's last
// pixel the shared divider runs twice (column mean, then row mean), one
// quotient bit per cycle, for QW-bit quotients with QW = clog2 of the
// larger max dimension; in_tready stays low until the result is loaded.
// The result word then sits in the output register; found travels on
// out_tuser. While it waits for out_tready the next frame's pixels are
// taken; only the next frame end holds until the old result is taken.
// Reset clears counters, sums and the output valid and loads the size
// registers with 640 x 480.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "color_blob_centroid_defines.svh"

module color_blob_centroid #(
  parameter int MAX_WIDTH  = cbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cbc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // cfg port
  input  logic                            cfg_we,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbc_pkg::REG_W-1:0]       cfg_wdata,
  // pixel stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cbc_pkg::IN_DATA_W-1:0]   in_tdata,   // red[7:0], green[15:8], blue[23:16]
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cbc_pkg::OUT_DATA_W-1:0]  out_tdata,  // center_x[9:0], center_y[19:10], zero
  output logic [0:0]                      out_tuser   // found[0]
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int QW    = (XW > YW) ? XW : YW;
  localparam int LW    = QW + 1;
  localparam int CMP_W = (cbc_pkg::REG_W > LW) ? cbc_pkg::REG_W : LW;
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SUM_W = QW + CNT_W;
  localparam int CW    = cbc_pkg::COORD_W;
  localparam int PW    = cbc_pkg::PROD_W;

  typedef enum logic [5:0] {
    ST_PIX  = 6'b000001,
    ST_LDX  = 6'b000010,
    ST_DIVX = 6'b000100,
    ST_LDY  = 6'b001000,
    ST_DIVY = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [cbc_pkg::REG_W-1:0] frame_width_r, frame_height_r;
  logic [XW-1:0]            col_r, col_nxt;
  logic [YW-1:0]            row_r, row_nxt;
  logic [SUM_W-1:0]         col_sum_r, col_sum_nxt;
  logic [SUM_W-1:0]         row_sum_r, row_sum_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [QW-1:0]            qx_r, qx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     found_r, found_nxt;
  logic [CW-1:0]            cx_r, cx_nxt;
  logic [CW-1:0]            cy_r, cy_nxt;

  logic [cbc_pkg::COLOR_W-1:0] red, green, blue;
  logic [PW-1:0]            red5, green5;
  logic                     match;
  logic                     in_accept;
  logic [CMP_W-1:0]         w_ext, h_ext, w_lim, h_lim;
  logic                     row_end, frame_end;

  cbc_pkg::div_status_t     div_stat;
  logic                     div_start;
  logic [SUM_W-1:0]         div_dividend;
  logic [QW-1:0]            div_q;
  logic [QW+CW-1:0]         qx_ext, qy_ext;

  // Size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= cbc_pkg::RST_FRAME_WIDTH;
      frame_height_r <= cbc_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      if (cfg_index == cbc_pkg::REG_FRAME_WIDTH) begin
        frame_width_r <= cfg_wdata;
      end else if (cfg_index == cbc_pkg::REG_FRAME_HEIGHT) begin
        frame_height_r <= cfg_wdata;
      end
    end
  end

  // Clamp sizes to 1..MAX
  always_comb begin
    w_ext = CMP_W'(frame_width_r);
    h_ext = CMP_W'(frame_height_r);
    if (w_ext == '0) begin
      w_lim = CMP_W'(1);
    end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
      w_lim = CMP_W'(MAX_WIDTH);
    end else begin
      w_lim = w_ext;
    end
    if (h_ext == '0) begin
      h_lim = CMP_W'(1);
    end else if (h_ext > CMP_W'(MAX_HEIGHT)) begin
      h_lim = CMP_W'(MAX_HEIGHT);
    end else begin
      h_lim = h_ext;
    end
  end

  // Color test and position wrap
  always_comb begin
    red       = in_tdata[7:0];
    green     = in_tdata[15:8];
    blue      = in_tdata[23:16];
    red5      = PW'(red) * PW'(cbc_pkg::MATCH_GAIN);
    green5    = PW'(green) * PW'(cbc_pkg::MATCH_GAIN);
    match     = (PW'(blue) > red5) && (PW'(blue) > green5);
    row_end   = (CMP_W'(col_r) + CMP_W'(1)) >= w_lim;
    frame_end = row_end && ((CMP_W'(row_r) + CMP_W'(1)) >= h_lim);
  end

  assign in_tready = (state_r == ST_PIX);
  assign in_accept = in_tvalid && in_tready;

  // Shared divider: column sum first, then row sum
  assign div_start    = (state_r == ST_LDX) || (state_r == ST_LDY);
  assign div_dividend = (state_r == ST_LDX) ? col_sum_r : row_sum_r;

  cbc_divider #(
    .QW    (QW),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cnt_r),
    .status   (div_stat),
    .quotient (div_q)
  );

  // Quotients to coordinate width
  assign qx_ext = {{CW{1'b0}}, qx_r};
  assign qy_ext = {{CW{1'b0}}, div_q};

  // Sequencer and accumulators
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    col_sum_nxt   = col_sum_r;
    row_sum_nxt   = row_sum_r;
    cnt_nxt       = cnt_r;
    qx_nxt        = qx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    found_nxt     = found_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    case (state_r)
      ST_PIX: begin
        if (in_accept) begin
          if (match) begin
            col_sum_nxt = col_sum_r + SUM_W'(col_r);
            row_sum_nxt = row_sum_r + SUM_W'(row_r);
            cnt_nxt     = cnt_r + CNT_W'(1);
          end
          if (!row_end) begin
            col_nxt = col_r + XW'(1);
          end else begin
            col_nxt = '0;
            if (!frame_end) begin
              row_nxt = row_r + YW'(1);
            end else begin
              state_nxt = ST_LDX;
            end
          end
        end
      end
      ST_LDX: begin
        state_nxt = ST_DIVX;
      end
      ST_DIVX: begin
        if (div_stat.done) begin
          qx_nxt    = div_q;
          state_nxt = ST_LDY;
        end
      end
      ST_LDY: begin
        state_nxt = ST_DIVY;
      end
      ST_DIVY: begin
        if (div_stat.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // load result once the output register is free, then clear the frame
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          found_nxt     = (cnt_r != '0);
          cx_nxt        = (cnt_r != '0) ? qx_ext[CW-1:0] : '0;
          cy_nxt        = (cnt_r != '0) ? qy_ext[CW-1:0] : '0;
          col_nxt       = '0;
          row_nxt       = '0;
          col_sum_nxt   = '0;
          row_sum_nxt   = '0;
          cnt_nxt       = '0;
          state_nxt     = ST_PIX;
        end
      end
      default: begin
        state_nxt = ST_PIX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_PIX;
      col_r       <= '0;
      row_r       <= '0;
      col_sum_r   <= '0;
      row_sum_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      col_sum_r   <= col_sum_nxt;
      row_sum_r   <= row_sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    qx_r    <= qx_nxt;
    found_r <= found_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
  end

  // Output word
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(cbc_pkg::OUT_DATA_W - 2 * CW){1'b0}}, cy_r, cx_r};
  assign out_tuser  = found_r;

  `CBC_ASSERT_IMPL(a_nofind_zero, out_tvalid && !out_tuser[0], out_tdata == '0, "empty frame result carries nonzero coordinates")
  `CBC_ASSERT_IMPL(a_done_in_div, div_stat.done, state_r == ST_DIVX || state_r == ST_DIVY, "divider finished outside a divide state")
  `CBC_ASSERT_IMPL(a_pix_div_idle, state_r == ST_PIX, !div_stat.busy, "divider busy while pixels are taken")
  `CBC_ASSERT_NEXT(a_frame_end_stall, in_accept && frame_end, state_r == ST_LDX && !in_tready, "frame end did not start the divide sequence")

endmodule

// ===== tb/color_blob_centroid_tb.sv =====
// ----------------------------------------------------------------------------
// color_blob_centroid_tb
// Self-checking bench for the blue blob centroid block.
// ----------------------------------------------------------------------------
// Pixel words go in on the in_ stream, and each frame end gives one result
// word. A scoreboard models the color test, the position counters and the
// sums. It queues the expected centroid for every frame end and checks each
// result word against it. Frame size registers change between phases once
// the block has gone quiet, often in the middle of a frame. Settings cover
// zero, one and above-maximum register values, the latter shrunk before the
// row ends. Both stream sides insert random bubbles, except in the closing
// stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module color_blob_centroid_tb;

  localparam int CFG_IDX_W  = cbc_pkg::CFG_IDX_W;
  localparam int REG_W      = cbc_pkg::REG_W;
  localparam int COORD_W    = cbc_pkg::COORD_W;
  localparam int IN_DATA_W  = cbc_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = cbc_pkg::OUT_DATA_W;

  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PIXELS = 650;
  localparam int QUIET_PIXELS  = 120;
  localparam longint TIMEOUT_NS = 5_000_000;
  localparam int MAX_REPORTS   = 10;

  // Indexes the block has no register for
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
  } blob_result_t;

  // --------------------------------------------------------------------------
  // Centroid scoreboard: frame state plus queue of pending centroids
  // --------------------------------------------------------------------------
  class blob_scoreboard;
    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;
    int unsigned      col_pos;
    int unsigned      row_pos;
    longint unsigned  col_sum;
    longint unsigned  row_sum;
    longint unsigned  hits;
    blob_result_t     centroid_q[$];
    int unsigned      errors;

    function new();
      width_reg  = cbc_pkg::RST_FRAME_WIDTH;
      height_reg = cbc_pkg::RST_FRAME_HEIGHT;
      col_pos    = 0;
      row_pos    = 0;
      col_sum    = 0;
      row_sum    = 0;
      hits       = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        cbc_pkg::REG_FRAME_WIDTH:  width_reg = val;
        cbc_pkg::REG_FRAME_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    // Sizes in use: zero acts as one, oversize saturates
    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > cbc_pkg::DEF_MAX_WIDTH) return cbc_pkg::DEF_MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > cbc_pkg::DEF_MAX_HEIGHT) return cbc_pkg::DEF_MAX_HEIGHT;
      return height_reg;
    endfunction

    function int unsigned frame_pixels();
      return eff_width() * eff_height();
    endfunction

    // True when the next pixel closes the frame
    function bit frame_end_next();
      return (col_pos + 1 >= eff_width()) && (row_pos + 1 >= eff_height());
    endfunction

    function int unsigned pending();
      return centroid_q.size();
    endfunction

    function void note_pixel(logic [IN_DATA_W-1:0] px);
      int unsigned  red;
      int unsigned  green;
      int unsigned  blue;
      blob_result_t res;
      red   = px[7:0];
      green = px[15:8];
      blue  = px[23:16];
      if (blue > cbc_pkg::MATCH_GAIN * red && blue > cbc_pkg::MATCH_GAIN * green) begin
        col_sum += col_pos;
        row_sum += row_pos;
        hits++;
      end
      // Advance position; a shrunk size ends the row/frame at once
      if (col_pos + 1 < eff_width()) begin
        col_pos++;
        return;
      end
      col_pos = 0;
      if (row_pos + 1 < eff_height()) begin
        row_pos++;
        return;
      end
      res.found    = (hits != 0);
      res.center_x = (hits != 0) ? COORD_W'(col_sum / hits) : '0;
      res.center_y = (hits != 0) ? COORD_W'(row_sum / hits) : '0;
      centroid_q.push_back(res);
      row_pos = 0;
      col_sum = 0;
      row_sum = 0;
      hits    = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t ERROR: %s", $realtime, msg);
    endfunction

    function void check_result(blob_result_t got);
      blob_result_t exp;
      if (centroid_q.size() == 0) begin
        report($sformatf("unexpected result found=%0d x=%0d y=%0d",
                         got.found, got.center_x, got.center_y));
        return;
      end
      exp = centroid_q.pop_front();
      if (got.found !== exp.found || got.center_x !== exp.center_x ||
          got.center_y !== exp.center_y)
        report($sformatf("expected found=%0d x=%0d y=%0d, got found=%0d x=%0d y=%0d",
                         exp.found, exp.center_x, exp.center_y,
                         got.found, got.center_x, got.center_y));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // center_x[9:0], center_y[19:10], zero
  logic [0:0]            out_tuser;       // found[0]

  blob_scoreboard sb = new();
  bit             idle_on = 1'b1;
  int unsigned    stall_left = 0;
  int unsigned    pixels_sent = 0;

  color_blob_centroid i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check accepted words, stall in short bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tuser[0], out_tdata[9:0], out_tdata[19:10]});
    if (stall_left != 0) stall_left--;
    else if (idle_on && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
    out_tready <= (stall_left == 0);
  end

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // One pixel word, with an optional bubble in front
  task automatic send_pixel(input logic [IN_DATA_W-1:0] px);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  // Hold the stream until all centroids are back and the divider is done
  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel word {blue, green, red}; density is the match chance in percent
  function automatic logic [IN_DATA_W-1:0] make_pixel(int unsigned density, bit raw);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    if (raw) return IN_DATA_W'($urandom_range(0, 24'hFFFFFF));
    if ($urandom_range(0, 99) < density) begin
      b = $urandom_range(1, 255);
      r = $urandom_range(0, (b - 1) / 5);
      g = $urandom_range(0, (b - 1) / 5);
    end else begin
      r = $urandom_range(0, 255);
      g = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
      case ($urandom_range(0, 3))
        0: begin               // blue exactly five times red
          r = $urandom_range(0, 51);
          b = 5 * r;
          g = $urandom_range(0, r);
        end
        1: begin               // blue exactly five times green
          g = $urandom_range(0, 51);
          b = 5 * g;
          r = $urandom_range(0, g);
        end
        default:
          if (b > 5 * r && b > 5 * g) r = (b + 4) / 5;
      endcase
    end
    return {b[7:0], g[7:0], r[7:0]};
  endfunction

  // Set the frame size, send some frames plus a ragged tail unless last_only, then drain
  task automatic run_phase(input int unsigned w, input int unsigned h,
                           input int unsigned density, input bit raw,
                           input bit last_only, input int unsigned nframes);
    int unsigned npix;
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                REG_W'($urandom_range(0, 2047)));
    if ($urandom_range(0, 1)) begin
      write_reg(cbc_pkg::REG_FRAME_WIDTH, REG_W'(w));
      write_reg(cbc_pkg::REG_FRAME_HEIGHT, REG_W'(h));
    end else begin
      write_reg(cbc_pkg::REG_FRAME_HEIGHT, REG_W'(h));
      write_reg(cbc_pkg::REG_FRAME_WIDTH, REG_W'(w));
    end
    cfg_we <= 1'b0;
    npix = nframes * sb.frame_pixels() + (last_only ? 0 : $urandom_range(0, 5));
    repeat (npix) begin
      if (last_only) send_pixel(make_pixel(sb.frame_end_next() ? 100 : 0, 1'b0));
      else send_pixel(make_pixel(density, raw));
    end
    drain_and_settle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned density;
    int unsigned random_goal;
    bit          raw;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Color test corners at the reset size (640x480, no frame end)
    send_pixel({8'd0,   8'd0,   8'd0});      // black
    send_pixel({8'd255, 8'd255, 8'd255});    // white
    send_pixel({8'd255, 8'd0,   8'd0});      // pure blue, match
    send_pixel({8'd255, 8'd0,   8'd51});     // blue ties 5x red
    send_pixel({8'd255, 8'd50,  8'd50});     // just above both, match
    send_pixel({8'd255, 8'd51,  8'd0});      // blue ties 5x green
    send_pixel({8'd1,   8'd0,   8'd0});      // faintest match
    send_pixel({8'd0,   8'd255, 8'd255});    // no blue
    drain_and_settle();

    // Writes to unused indexes change nothing; then shrink mid-frame
    write_reg(REG_SPARE_A, 11'h7FF);
    write_reg(REG_SPARE_B, 11'h555);
    write_reg(cbc_pkg::REG_FRAME_WIDTH, 11'd3);
    write_reg(cbc_pkg::REG_FRAME_HEIGHT, 11'd2);
    cfg_we <= 1'b0;
    send_pixel({8'd200, 8'd10, 8'd10});
    send_pixel({8'd0,   8'd0,  8'd0});
    send_pixel({8'd90,  8'd17, 8'd3});
    send_pixel({8'd100, 8'd0,  8'd20});
    drain_and_settle();

    // Zero sizes act as 1x1: every pixel is a frame
    write_reg(cbc_pkg::REG_FRAME_WIDTH, 11'd0);
    write_reg(cbc_pkg::REG_FRAME_HEIGHT, 11'd0);
    cfg_we <= 1'b0;
    send_pixel({8'd255, 8'd0,  8'd0});
    send_pixel({8'd10,  8'd2,  8'd2});
    send_pixel({8'd6,   8'd1,  8'd1});
    drain_and_settle();

    // Oversize sizes saturate; a shrink to 2x1 then closes the frame early
    write_reg(cbc_pkg::REG_FRAME_WIDTH, 11'd2047);
    write_reg(cbc_pkg::REG_FRAME_HEIGHT, 11'd1500);
    cfg_we <= 1'b0;
    send_pixel({8'd120, 8'd3,  8'd4});
    send_pixel({8'd0,   8'd9,  8'd9});
    send_pixel({8'd250, 8'd0,  8'd49});
    drain_and_settle();
    write_reg(cbc_pkg::REG_FRAME_WIDTH, 11'd2);
    write_reg(cbc_pkg::REG_FRAME_HEIGHT, 11'd1);
    cfg_we <= 1'b0;
    send_pixel({8'd77,  8'd15, 8'd0});
    drain_and_settle();

    run_phase(1, 1, 100, 1'b0, 1'b0, 3);

    // Random frames, mostly small
    random_goal = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < random_goal) begin
      idle_on = (random_goal - pixels_sent > QUIET_PIXELS) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0: begin
          w = 0;
          h = $urandom_range(0, 4);
        end
        1: begin
          w = $urandom_range(1, 8);
          h = 0;
        end
        2: begin
          w = $urandom_range(1, 3);
          h = $urandom_range(1, 40);
        end
        default: begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 6);
        end
      endcase
      raw = 1'b0;
      case ($urandom_range(0, 4))
        0: density = 0;
        1: density = 10;
        2: density = 50;
        3: density = 100;
        default: begin
          density = 0;
          raw     = 1'b1;
        end
      endcase
      run_phase(w, h, density, raw, $urandom_range(0, 9) == 0,
                (h > 6) ? 1 : $urandom_range(1, 3));
    end

    idle_on = 1'b0;
    drain_and_settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/cbc_pkg.sv
sv/cbc_divider.sv
sv/color_blob_centroid.sv
tb/color_blob_centroid_tb.sv
